@@ rtl/bsar_pkg.sv @@
// ----------------------------------------------------------------------------
// bsar_pkg
// Shared types and constants of the bus slave acknowledgment responder:
// register indexes, reset values and the control structs that pass between
// the responder and its key queue.
// ----------------------------------------------------------------------------
package bsar_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_OWN_ADDRESS    = 3'd0;
	localparam logic [2:0] REG_SNIFF_ONLY     = 3'd1;
	localparam logic [2:0] REG_PROMISCUOUS    = 3'd2;
	localparam logic [2:0] REG_MASTER_ADDRESS = 3'd3;
	localparam logic [2:0] REG_ACK_COMMAND    = 3'd4;
	localparam logic [2:0] REG_ECHO_WINDOW_US = 3'd5;

	// Register reset values.
	localparam logic [7:0]  ACK_COMMAND_RST    = 8'd1;
	localparam logic [31:0] ECHO_WINDOW_US_RST = 32'd5000;

	// Request type codes.
	localparam logic REQ_PACKET = 1'b0;
	localparam logic REQ_KEY    = 1'b1;

	// An echo carries at least this many payload bytes.
	localparam logic [7:0] MIN_ECHO_LEN = 8'd2;

	// Key sent in an ack when the queue is empty.
	localparam logic [7:0] KEY_NONE = 8'd0;

	typedef struct packed {
		logic push;
		logic pop;
	} queue_op_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

endpackage

@@ rtl/bus_slave_ack_responder.sv @@
// ----------------------------------------------------------------------------
// bus_slave_ack_responder
// Responder for a slave node on a multidrop serial bus. It takes one item per
// clock while in_stall is low, either a received packet or a host key press,
// and gives one result per item: the item is captured in an input register,
// decided in one pass of compares and 32-bit subtractions against the node
// state, and written to a result register. The key queue keeps its oldest
// key prefetched from its RAM, so a pop does not wait on a RAM read. A result
// waiting in the output register does not block the next input transfer;
// input stall rises only when both registers hold items and the output
// is stalled.
// ----------------------------------------------------------------------------
module bus_slave_ack_responder #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [7:0]  dest,
	input  logic [7:0]  command,
	input  logic [7:0]  payload_len,
	input  logic [7:0]  second_byte,
	input  logic [31:0] rx_time_us,
	input  logic [31:0] ack_time_us,
	input  logic [7:0]  keycode,

	output logic        out_valid,
	input  logic        out_stall,
	output logic        echo_dropped,
	output logic        snoop_out,
	output logic        deliver_packet,
	output logic        send_ack,
	output logic [7:0]  ack_key,
	output logic [31:0] ack_delay_us,
	output logic        key_accepted,
	output logic [3:0]  pending_keys,
	output logic [31:0] echo_count,
	output logic        online
);

	import bsar_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	// Configuration registers.
	logic [7:0]  own_address_q;
	logic        sniff_only_q;
	logic        promiscuous_q;
	logic [7:0]  master_address_q;
	logic [7:0]  ack_command_q;
	logic [31:0] echo_window_us_q;

	// Node state.
	logic [31:0] last_ack_time_q;
	logic [7:0]  last_sent_key_q;
	logic [31:0] echo_counter_q;
	logic        online_q;

	// Input register.
	logic        valid_s1;
	logic        req_type_s1;
	logic [7:0]  dest_s1;
	logic [7:0]  command_s1;
	logic [7:0]  payload_len_s1;
	logic [7:0]  second_byte_s1;
	logic [31:0] rx_time_us_s1;
	logic [31:0] ack_time_us_s1;
	logic [7:0]  keycode_s1;

	// Result register.
	logic        valid_s2;
	logic        echo_dropped_s2;
	logic        snoop_out_s2;
	logic        deliver_packet_s2;
	logic        send_ack_s2;
	logic [7:0]  ack_key_s2;
	logic [31:0] ack_delay_us_s2;
	logic        key_accepted_s2;
	logic [3:0]  pending_keys_s2;
	logic [31:0] echo_count_s2;
	logic        online_s2;

	// Decision logic.
	logic            advance;
	logic            fire;
	logic            is_key;
	logic [31:0]     echo_age;
	logic [31:0]     latency;
	logic            is_echo;
	logic            to_us;
	logic            do_ack;
	logic            do_push;
	logic            do_pop;
	logic [7:0]      sent_key;
	logic [31:0]     echo_counter_nxt;
	logic [PTR_W-1:0] count;
	logic [PTR_W-1:0] count_nxt;
	logic [PTR_W+3:0] count_ext;

	queue_op_t     q_op;
	queue_status_t q_status;
	logic [7:0]    head_key;

	// ---------------- configuration port ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q    <= '0;
			sniff_only_q     <= 1'b0;
			promiscuous_q    <= 1'b0;
			master_address_q <= '0;
			ack_command_q    <= ACK_COMMAND_RST;
			echo_window_us_q <= ECHO_WINDOW_US_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_OWN_ADDRESS:    own_address_q    <= cfg_data[7:0];
				REG_SNIFF_ONLY:     sniff_only_q     <= cfg_data[0];
				REG_PROMISCUOUS:    promiscuous_q    <= cfg_data[0];
				REG_MASTER_ADDRESS: master_address_q <= cfg_data[7:0];
				REG_ACK_COMMAND:    ack_command_q    <= cfg_data[7:0];
				REG_ECHO_WINDOW_US: echo_window_us_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// ---------------- handshake ----------------
	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_type_s1    <= req_type;
			dest_s1        <= dest;
			command_s1     <= command;
			payload_len_s1 <= payload_len;
			second_byte_s1 <= second_byte;
			rx_time_us_s1  <= rx_time_us;
			ack_time_us_s1 <= ack_time_us;
			keycode_s1     <= keycode;
		end
	end

	// ---------------- decision ----------------
	assign is_key   = (req_type_s1 == REQ_KEY);
	assign echo_age = rx_time_us_s1 - last_ack_time_q;
	assign latency  = ack_time_us_s1 - rx_time_us_s1;

	// A last ack time of zero means no ack has gone out yet.
	assign is_echo = !is_key && !sniff_only_q
		&& (dest_s1 == master_address_q)
		&& (command_s1 == ack_command_q)
		&& (last_ack_time_q != '0)
		&& (echo_age <= echo_window_us_q)
		&& (payload_len_s1 >= MIN_ECHO_LEN)
		&& (second_byte_s1 == last_sent_key_q);

	assign to_us    = !is_key && !is_echo && (dest_s1 == own_address_q);
	assign do_ack   = to_us && !sniff_only_q;
	assign do_push  = is_key && !q_status.full;
	assign do_pop   = do_ack && !q_status.empty;
	assign sent_key = do_pop ? head_key : KEY_NONE;

	assign echo_counter_nxt = is_echo ? echo_counter_q + 32'd1 : echo_counter_q;

	assign q_op.push = fire && do_push;
	assign q_op.pop  = fire && do_pop;

	always_comb begin
		priority if (do_push) begin
			count_nxt = count + PTR_W'(1);
		end else if (do_pop) begin
			count_nxt = count - PTR_W'(1);
		end else begin
			count_nxt = count;
		end
	end

	assign count_ext = {4'b0000, count_nxt};

	bsar_key_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_key_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (q_op),
		.push_key(keycode_s1),
		.status  (q_status),
		.head_key(head_key),
		.count   (count)
	);

	// ---------------- node state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_ack_time_q <= '0;
			last_sent_key_q <= '0;
			echo_counter_q  <= '0;
			online_q        <= 1'b0;
		end else if (fire) begin
			echo_counter_q <= echo_counter_nxt;
			if (do_ack) begin
				last_ack_time_q <= ack_time_us_s1;
				last_sent_key_q <= sent_key;
				online_q        <= 1'b1;
			end
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk) begin
		if (fire) begin
			echo_dropped_s2   <= is_echo;
			snoop_out_s2      <= !is_key && !is_echo && promiscuous_q;
			deliver_packet_s2 <= to_us;
			send_ack_s2       <= do_ack;
			ack_key_s2        <= sent_key;
			ack_delay_us_s2   <= do_ack ? latency : '0;
			key_accepted_s2   <= do_push;
			pending_keys_s2   <= count_ext[3:0];
			echo_count_s2     <= echo_counter_nxt;
			online_s2         <= online_q || do_ack;
		end
	end

	assign out_valid      = valid_s2;
	assign echo_dropped   = echo_dropped_s2;
	assign snoop_out      = snoop_out_s2;
	assign deliver_packet = deliver_packet_s2;
	assign send_ack       = send_ack_s2;
	assign ack_key        = ack_key_s2;
	assign ack_delay_us   = ack_delay_us_s2;
	assign key_accepted   = key_accepted_s2;
	assign pending_keys   = pending_keys_s2;
	assign echo_count     = echo_count_s2;
	assign online         = online_s2;

	// ---------------- assertions ----------------
	a_online_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		online_q |=> online_q)
		else $error("online flag cleared after an ack was sent");

	a_echo_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && is_echo) |=> (echo_counter_q == $past(echo_counter_q) + 32'd1))
		else $error("echo counter did not advance by one on a dropped echo");

	a_echo_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && echo_dropped_s2) |->
			(!send_ack_s2 && !deliver_packet_s2 && !snoop_out_s2))
		else $error("dropped echo also delivered, snooped or acked");

	a_ack_online: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && send_ack_s2) |-> online_s2)
		else $error("ack result reports node offline");

	a_no_bubble_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> !in_stall)
		else $error("input stalled while the result register is empty");

endmodule

@@ rtl/bsar_ram.sv @@
// ----------------------------------------------------------------------------
// bsar_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module bsar_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/bsar_key_queue.sv @@
// ----------------------------------------------------------------------------
// bsar_key_queue
// Ring queue of host key codes that always keeps one slot free. The RAM read
// port is aimed at the slot that will be the oldest entry next cycle, so the
// key to pop is ready without waiting; a write into that same slot is
// forwarded around the RAM.
// ----------------------------------------------------------------------------
module bsar_key_queue #(
	parameter int DEPTH = 16,
	localparam int PTR_W = $clog2(DEPTH)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bsar_pkg::queue_op_t     op,
	input  logic [7:0]              push_key,
	output bsar_pkg::queue_status_t status,
	output logic [7:0]              head_key,
	output logic [PTR_W-1:0]        count
);

	import bsar_pkg::*;

	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [PTR_W-1:0] head_inc;
	logic [PTR_W-1:0] tail_inc;
	logic [PTR_W-1:0] raddr;
	logic [PTR_W:0]   diff;
	logic [PTR_W:0]   diff_wrapped;
	logic [7:0]       rdata;
	logic             fwd_q;
	logic [7:0]       fwd_key_q;

	assign head_inc = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
	assign tail_inc = (tail_q == PTR_W'(DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);

	assign status.empty = (head_q == tail_q);
	assign status.full  = (head_inc == tail_q);

	assign diff         = {1'b0, head_q} - {1'b0, tail_q};
	assign diff_wrapped = diff + (PTR_W+1)'(DEPTH);
	assign count = (head_q >= tail_q) ? diff[PTR_W-1:0] : diff_wrapped[PTR_W-1:0];

	// Read the slot that is the oldest entry after this cycle's update.
	assign raddr = op.pop ? tail_inc : tail_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fwd_q  <= 1'b0;
		end else begin
			if (op.push) begin
				head_q <= head_inc;
			end
			if (op.pop) begin
				tail_q <= tail_inc;
			end
			fwd_q <= op.push && (head_q == raddr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_key_q <= push_key;
	end

	bsar_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (op.push),
		.waddr(head_q),
		.wdata(push_key),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign head_key = fwd_q ? fwd_key_q : rdata;

endmodule
